// ===== src/tte_pkg.sv =====
// tap tempo estimator package: widths, reset values, register indexes,
// configuration struct and state types
// no dependencies
`default_nettype none

package tte_pkg;

    localparam int TAP_DEPTH_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam int CENTI_MS_PER_MIN = 6000000;
    localparam int CFG_W            = 16;
    localparam int ADDR_W           = 3;
    localparam int USED_W           = 3;
    localparam int GAP_W            = 16;
    localparam int MAX_GAP          = 65535;

    localparam logic [ADDR_W-1:0] REG_RESET_GAP    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_MIN_INTERVAL = 3'd1;
    localparam logic [ADDR_W-1:0] REG_MAX_INTERVAL = 3'd2;
    localparam logic [ADDR_W-1:0] REG_MIN_TEMPO    = 3'd3;
    localparam logic [ADDR_W-1:0] REG_MAX_TEMPO    = 3'd4;

    localparam logic [CFG_W-1:0] RESET_GAP_RST    = 16'd2000;
    localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 16'd100;
    localparam logic [CFG_W-1:0] MAX_INTERVAL_RST = 16'd2000;
    localparam logic [CFG_W-1:0] MIN_TEMPO_RST    = 16'd2000;
    localparam logic [CFG_W-1:0] MAX_TEMPO_RST    = 16'd30000;

    localparam logic [GAP_W-1:0]  GAP_SAT  = 16'hFFFF;
    localparam logic [USED_W-1:0] USED_MAX = 3'd7;

    typedef struct packed {
        logic [CFG_W-1:0] reset_gap;
        logic [CFG_W-1:0] min_interval;
        logic [CFG_W-1:0] max_interval;
        logic [CFG_W-1:0] min_tempo;
        logic [CFG_W-1:0] max_tempo;
    } cfg_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SUM,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== src/tte_front.sv =====
// front part: takes taps, keeps the gap history, sums in-range window gaps
// depends on tte_pkg
`default_nettype none

module tte_front #(
    parameter int TAP_DEPTH = tte_pkg::TAP_DEPTH_DEF,
    localparam int GAP_DEPTH = TAP_DEPTH - 1,
    localparam int CW = $clog2(TAP_DEPTH),
    localparam int IW = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1,
    localparam int SW = $clog2(GAP_DEPTH * tte_pkg::MAX_GAP + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [31:0]         tap_time_ms,
    input  wire tte_pkg::cfg_t       cfg,
    output logic                     job_push,
    input  wire logic                job_full,
    output logic [SW-1:0]            job_sum,
    output logic [CW-1:0]            job_cnt
);

    tte_pkg::front_state_t state_reg, state_next;

    logic                      has_tap_reg;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [31:0]               last_reg;
    logic [tte_pkg::GAP_W-1:0] gaps_reg [GAP_DEPTH];
    logic [CW-1:0]             idx_reg, idx_next;
    logic [SW-1:0]             acc_reg, acc_next;
    logic [CW-1:0]             n_reg, n_next;

    logic                      accept;
    logic [31:0]               gap_full;
    logic                      clear;
    logic                      first;
    logic [tte_pkg::GAP_W-1:0] gap_sat;
    logic [tte_pkg::GAP_W-1:0] cur;
    logic                      hit;
    logic [SW-1:0]             acc_add;
    logic [CW-1:0]             n_add;
    logic                      last_idx;

    assign accept   = push && (state_reg == tte_pkg::F_IDLE);
    assign full     = (state_reg != tte_pkg::F_IDLE);
    assign gap_full = tap_time_ms - last_reg;
    assign clear    = has_tap_reg && (gap_full > {16'd0, cfg.reset_gap});
    assign first    = !has_tap_reg || clear;
    assign gap_sat  = (|gap_full[31:16]) ? tte_pkg::GAP_SAT : gap_full[15:0];

    assign cur      = gaps_reg[idx_reg[IW-1:0]];
    assign hit      = (cur > cfg.min_interval) && (cur < cfg.max_interval);
    assign acc_add  = acc_reg + (hit ? SW'(cur) : SW'(0));
    assign n_add    = n_reg + CW'(hit);
    assign last_idx = (idx_reg == cnt_reg - 1'b1);

    assign job_sum = acc_reg;
    assign job_cnt = n_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        job_push   = 1'b0;
        case (state_reg)
            tte_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    if (first)
                        cnt_next = '0;
                    else if (cnt_reg != CW'(GAP_DEPTH))
                        cnt_next = cnt_reg + 1'b1;
                    if (!first)
                    begin
                        state_next = tte_pkg::F_SUM;
                        idx_next   = '0;
                        acc_next   = '0;
                        n_next     = '0;
                    end
                end
            end
            tte_pkg::F_SUM:
            begin
                acc_next = acc_add;
                n_next   = n_add;
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                    state_next = tte_pkg::F_PUSH;
            end
            tte_pkg::F_PUSH:
            begin
                job_push = (n_reg != '0) && !job_full;
                if ((n_reg == '0) || !job_full)
                    state_next = tte_pkg::F_IDLE;
            end
            default:
            begin
                state_next = tte_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tte_pkg::F_IDLE;
            has_tap_reg <= 1'b0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            n_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            if (accept)
                has_tap_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (accept)
        begin
            last_reg <= tap_time_ms;
            if (!first)
            begin
                gaps_reg[0] <= gap_sat;
                for (int k = 1; k < GAP_DEPTH; k++)
                    gaps_reg[k] <= gaps_reg[k-1];
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(GAP_DEPTH))
        else $error("gap count beyond history depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (n_reg != '0) && (acc_reg >= SW'(n_reg)))
        else $error("job pushed with no counted gap or short sum");

endmodule

`default_nettype wire

// ===== src/tte_fifo.sv =====
// small register queue between the front and back parts
// depends on no other file
`default_nettype none

module tte_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ===== src/tte_back.sv =====
// back part: bit-serial divide of 6000000 * count by the gap sum, clamp,
// result register; depends on tte_pkg
`default_nettype none

module tte_back #(
    parameter int TAP_DEPTH = tte_pkg::TAP_DEPTH_DEF,
    localparam int GAP_DEPTH = TAP_DEPTH - 1,
    localparam int CW = $clog2(TAP_DEPTH),
    localparam int SW = $clog2(GAP_DEPTH * tte_pkg::MAX_GAP + 1),
    localparam int NW = $clog2(tte_pkg::CENTI_MS_PER_MIN * GAP_DEPTH + 1),
    localparam int KW = $clog2(NW + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        job_empty,
    output logic                             job_pop,
    input  wire logic [SW-1:0]               job_sum,
    input  wire logic [CW-1:0]               job_cnt,
    input  wire tte_pkg::cfg_t               cfg,
    input  wire logic                        pop,
    output logic                             empty,
    output logic [tte_pkg::CFG_W-1:0]        tempo_centi_bpm,
    output logic [tte_pkg::USED_W-1:0]       intervals_used
);

    tte_pkg::back_state_t state_reg, state_next;

    logic [NW-1:0]               dvd_reg, dvd_next;
    logic [SW-1:0]               rem_reg, rem_next;
    logic [SW-1:0]               sum_reg, sum_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [KW-1:0]               step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    logic [tte_pkg::CFG_W-1:0]   tempo_reg;
    logic [tte_pkg::USED_W-1:0]  used_reg;

    logic [SW:0]                 rem_sh;
    logic [SW:0]                 diff;
    logic                        ge;
    logic                        out_load;
    logic [tte_pkg::CFG_W-1:0]   tempo_res;
    logic [CW+2:0]               cnt_ext;
    logic [tte_pkg::USED_W-1:0]  used_res;

    assign rem_sh = {rem_reg, dvd_reg[NW-1]};
    assign diff   = rem_sh - {1'b0, sum_reg};
    assign ge     = (rem_sh >= {1'b0, sum_reg});

    assign cnt_ext  = (CW+3)'(cnt_reg);
    assign used_res = (cnt_ext > (CW+3)'(tte_pkg::USED_MAX)) ? tte_pkg::USED_MAX
                                                             : cnt_ext[tte_pkg::USED_W-1:0];

    always_comb
    begin
        if (dvd_reg < NW'(cfg.min_tempo))
            tempo_res = cfg.min_tempo;
        else if (dvd_reg > NW'(cfg.max_tempo))
            tempo_res = cfg.max_tempo;
        else
            tempo_res = dvd_reg[tte_pkg::CFG_W-1:0];
    end

    assign out_load = (state_reg == tte_pkg::B_DONE) && (!out_valid_reg || pop);
    assign job_pop  = (state_reg == tte_pkg::B_IDLE) && !job_empty;

    always_comb
    begin
        state_next = state_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        case (state_reg)
            tte_pkg::B_IDLE:
            begin
                if (!job_empty)
                begin
                    dvd_next   = NW'(job_cnt) * NW'(tte_pkg::CENTI_MS_PER_MIN);
                    rem_next   = '0;
                    sum_next   = job_sum;
                    cnt_next   = job_cnt;
                    step_next  = '0;
                    state_next = tte_pkg::B_DIV;
                end
            end
            tte_pkg::B_DIV:
            begin
                rem_next  = ge ? diff[SW-1:0] : rem_sh[SW-1:0];
                dvd_next  = {dvd_reg[NW-2:0], ge};
                step_next = step_reg + 1'b1;
                if (step_reg == KW'(NW - 1))
                    state_next = tte_pkg::B_DONE;
            end
            tte_pkg::B_DONE:
            begin
                if (out_load)
                    state_next = tte_pkg::B_IDLE;
            end
            default:
            begin
                state_next = tte_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tte_pkg::B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        sum_reg <= sum_next;
        cnt_reg <= cnt_next;
        if (out_load)
        begin
            tempo_reg <= tempo_res;
            used_reg  <= used_res;
        end
    end

    assign empty           = !out_valid_reg;
    assign tempo_centi_bpm = tempo_reg;
    assign intervals_used  = used_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tte_pkg::B_DONE) |-> (rem_reg < sum_reg))
        else $error("divider remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (tempo_reg >= cfg.min_tempo) || (tempo_reg == cfg.max_tempo))
        else $error("tempo outside clamp limits");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (used_reg != '0))
        else $error("result with no intervals used");

endmodule

`default_nettype wire

// ===== src/tap_tempo_estimator.sv =====
// tap tempo estimator top level: configuration registers, front, queue, back
// depends on tte_pkg, tte_front, tte_fifo, tte_back
//
//  channel  | handshake         | payload
//  ---------+-------------------+----------------------------------------
//  taps     | push / full       | tap_time_ms[31:0]
//  results  | pop / empty       | tempo_centi_bpm[15:0], intervals_used[2:0]
//  config   | cfg_wr            | cfg_addr[2:0], cfg_data[15:0]
//
// front: takes a tap, sums the stored gaps of the window one by one, then
// hands the job on, waiting while the queue is full
// back: one quotient bit per cycle; the divider sets the sustained rate for
// taps that give a result
// reset clears the history and loads the register defaults; no sweep needed
// a waiting result holds the back part; full stays high while a job waits
`default_nettype none

module tap_tempo_estimator #(
    parameter int TAP_DEPTH   = tte_pkg::TAP_DEPTH_DEF,
    parameter int QUEUE_DEPTH = tte_pkg::QUEUE_DEPTH_DEF,
    localparam int GAP_DEPTH = TAP_DEPTH - 1,
    localparam int CW = $clog2(TAP_DEPTH),
    localparam int SW = $clog2(GAP_DEPTH * tte_pkg::MAX_GAP + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [31:0]                   tap_time_ms,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [tte_pkg::CFG_W-1:0]          tempo_centi_bpm,
    output logic [tte_pkg::USED_W-1:0]         intervals_used,
    input  wire logic                          cfg_wr,
    input  wire logic [tte_pkg::ADDR_W-1:0]    cfg_addr,
    input  wire logic [tte_pkg::CFG_W-1:0]     cfg_data
);

    tte_pkg::cfg_t cfg_reg, cfg_next;

    logic          job_push;
    logic          job_full;
    logic [SW-1:0] job_sum;
    logic [CW-1:0] job_cnt;
    logic          job_pop;
    logic          job_empty;
    logic [SW-1:0] q_sum;
    logic [CW-1:0] q_cnt;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_addr)
                tte_pkg::REG_RESET_GAP:    cfg_next.reset_gap    = cfg_data;
                tte_pkg::REG_MIN_INTERVAL: cfg_next.min_interval = cfg_data;
                tte_pkg::REG_MAX_INTERVAL: cfg_next.max_interval = cfg_data;
                tte_pkg::REG_MIN_TEMPO:    cfg_next.min_tempo    = cfg_data;
                tte_pkg::REG_MAX_TEMPO:    cfg_next.max_tempo    = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_gap    <= tte_pkg::RESET_GAP_RST;
            cfg_reg.min_interval <= tte_pkg::MIN_INTERVAL_RST;
            cfg_reg.max_interval <= tte_pkg::MAX_INTERVAL_RST;
            cfg_reg.min_tempo    <= tte_pkg::MIN_TEMPO_RST;
            cfg_reg.max_tempo    <= tte_pkg::MAX_TEMPO_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tte_front #(
        .TAP_DEPTH (TAP_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .tap_time_ms (tap_time_ms),
        .cfg         (cfg_reg),
        .job_push    (job_push),
        .job_full    (job_full),
        .job_sum     (job_sum),
        .job_cnt     (job_cnt)
    );

    tte_fifo #(
        .WIDTH (SW + CW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data ({job_sum, job_cnt}),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data ({q_sum, q_cnt}),
        .empty   (job_empty)
    );

    tte_back #(
        .TAP_DEPTH (TAP_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_empty       (job_empty),
        .job_pop         (job_pop),
        .job_sum         (q_sum),
        .job_cnt         (q_cnt),
        .cfg             (cfg_reg),
        .pop             (pop),
        .empty           (empty),
        .tempo_centi_bpm (tempo_centi_bpm),
        .intervals_used  (intervals_used)
    );

endmodule

`default_nettype wire
